### hdl/rfns_pkg.sv
// Shared types and constants for the running five-number summary unit.
// No dependencies; every other file in hdl/ imports this package.
`timescale 1ns / 1ps

package rfns_pkg;

  localparam int SAMPLE_W            = 32;
  localparam int MEDIAN_W            = 33;
  localparam int COUNT_W             = 9;
  // Wide enough to index the largest supported store (4096 entries).
  localparam int TAP_W               = 12;
  localparam int DEFAULT_STORE_DEPTH = 256;

  // Sorted positions that one result reads from the cell chain.
  typedef struct packed {
    logic [TAP_W-1:0] q1;
    logic [TAP_W-1:0] q3;
    logic [TAP_W-1:0] mid_lo;
    logic [TAP_W-1:0] mid_hi;
    logic [TAP_W-1:0] last;
  } rfns_taps_t;

  // Per-cell control from the chain controller.
  typedef struct packed {
    logic insert;
    logic occupied;
    logic tail;
  } rfns_cell_ctl_t;

endpackage

### hdl/rfns_cell.sv
// One cell of the sorted insertion chain: holds a single stored sample.
// Depends on rfns_pkg.
`timescale 1ns / 1ps

module rfns_cell (
  input  logic                                 clk,
  input  rfns_pkg::rfns_cell_ctl_t             ctl,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0] left_value,
  input  logic                                 left_greater,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] value,
  output logic                                 greater
);
  import rfns_pkg::*;

  logic signed [SAMPLE_W-1:0] value_next;

  // Equal samples stay in front of the new one, so only a strictly larger
  // entry moves right.
  assign greater = ctl.occupied && (value > sample);

  always_comb begin
    value_next = value;
    if (ctl.insert) begin
      if (left_greater) begin
        value_next = left_value;
      end else if (greater || ctl.tail) begin
        value_next = sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### hdl/rfns_select.sv
// Picks the summary entries out of the cell chain and registers them.
// Depends on rfns_pkg.
`timescale 1ns / 1ps

module rfns_select #(
  parameter int STORE_DEPTH = rfns_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0] cell_value [STORE_DEPTH],
  input  rfns_pkg::rfns_taps_t                 taps,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] min_sel,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] q1_sel,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] q3_sel,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] lo_sel,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] hi_sel,
  output logic signed [rfns_pkg::SAMPLE_W-1:0] max_sel
);
  import rfns_pkg::*;

  logic [SAMPLE_W-1:0] q1_or;
  logic [SAMPLE_W-1:0] q3_or;
  logic [SAMPLE_W-1:0] lo_or;
  logic [SAMPLE_W-1:0] hi_or;
  logic [SAMPLE_W-1:0] max_or;

  // Each cell matches its own position against the taps; the matches are
  // one-hot per tap, so an AND-OR merge selects the entry.
  always_comb begin
    q1_or  = '0;
    q3_or  = '0;
    lo_or  = '0;
    hi_or  = '0;
    max_or = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      q1_or  = q1_or  | ({SAMPLE_W{taps.q1     == TAP_W'(i)}} & cell_value[i]);
      q3_or  = q3_or  | ({SAMPLE_W{taps.q3     == TAP_W'(i)}} & cell_value[i]);
      lo_or  = lo_or  | ({SAMPLE_W{taps.mid_lo == TAP_W'(i)}} & cell_value[i]);
      hi_or  = hi_or  | ({SAMPLE_W{taps.mid_hi == TAP_W'(i)}} & cell_value[i]);
      max_or = max_or | ({SAMPLE_W{taps.last   == TAP_W'(i)}} & cell_value[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      min_sel <= cell_value[0];
      q1_sel  <= q1_or;
      q3_sel  <= q3_or;
      lo_sel  <= lo_or;
      hi_sel  <= hi_or;
      max_sel <= max_or;
    end
  end

endmodule

### hdl/running_five_number_summary_unit.sv
// Running five-number summary unit: sorted cell chain, tap select, output register.
// Stages: cell chain with pending registers, select register, output register.
// Throughput: one sample per cycle while out_ready is high; the cell chain inserts
// on the accepting edge; tap select and median adder each take one register stage.
// Reset (rst, synchronous, active high) empties the store and the pipeline; the
// cell contents are not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps

module running_five_number_summary_unit #(
  parameter int STORE_DEPTH = rfns_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [rfns_pkg::SAMPLE_W-1:0]  minimum,
  output logic signed [rfns_pkg::SAMPLE_W-1:0]  first_quartile,
  output logic signed [rfns_pkg::MEDIAN_W-1:0]  median_doubled,
  output logic signed [rfns_pkg::SAMPLE_W-1:0]  third_quartile,
  output logic signed [rfns_pkg::SAMPLE_W-1:0]  maximum,
  output logic        [rfns_pkg::COUNT_W-1:0]   stored_count,
  output logic                                  dropped
);
  import rfns_pkg::*;

  // The count must be able to hold the depth itself.
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  // Fill state of the sorted store.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             full;
  logic             accept;
  logic             insert_en;

  // Cell chain wiring.
  logic signed [SAMPLE_W-1:0] cell_value   [STORE_DEPTH];
  logic                       cell_greater [STORE_DEPTH];

  // Pending stage: the chain already holds this transaction's sample and the
  // tap positions wait for the select stage.
  logic                   pend_valid;
  rfns_taps_t             pend_taps;
  rfns_taps_t             taps_next;
  logic [CNT_W-1:0]       pend_count;
  logic                   pend_dropped;
  logic                   pend_go;

  // Select stage: the chosen entries, registered inside rfns_select.
  logic                   sel_valid;
  logic [CNT_W-1:0]       sel_count;
  logic                   sel_dropped;
  logic                   sel_go;
  logic signed [SAMPLE_W-1:0] min_sel;
  logic signed [SAMPLE_W-1:0] q1_sel;
  logic signed [SAMPLE_W-1:0] q3_sel;
  logic signed [SAMPLE_W-1:0] lo_sel;
  logic signed [SAMPLE_W-1:0] hi_sel;
  logic signed [SAMPLE_W-1:0] max_sel;
  logic signed [MEDIAN_W-1:0] median_next;

  // Tap arithmetic on the count after this transaction.
  logic [CNT_W+1:0] three_n;
  logic [CNT_W-1:0] mid;

  // The output register drains when taken; each earlier stage moves on when
  // the stage after it is empty or moving too.
  assign sel_go   = sel_valid && (!out_valid || out_ready);
  assign pend_go  = pend_valid && (!sel_valid || sel_go);
  assign in_ready = !pend_valid || pend_go;
  assign accept   = in_valid && in_ready;

  assign full      = (count == CNT_W'(STORE_DEPTH));
  assign insert_en = accept && !full;

  // A full store drops the sample and reports the summary unchanged.
  assign count_next = full ? count : count + CNT_W'(1);

  // Positions floor(n/4), floor(3n/4), the middle pair and the last entry.
  // For odd n both middle taps point at the same entry, so the sum is twice it.
  always_comb begin
    three_n          = {2'b00, count_next} + {1'b0, count_next, 1'b0};
    mid              = count_next >> 1;
    taps_next.q1     = TAP_W'(count_next >> 2);
    taps_next.q3     = TAP_W'(three_n >> 2);
    taps_next.mid_hi = TAP_W'(mid);
    taps_next.mid_lo = count_next[0] ? TAP_W'(mid) : TAP_W'(mid - CNT_W'(1));
    taps_next.last   = TAP_W'(count_next - CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (insert_en) begin
      count <= count_next;
    end
  end

  // The chain of cells. Every cell compares the new sample with its entry; a
  // larger entry shifts one place right and the first free slot past the
  // smaller entries takes the sample, all in the cycle of the transaction.
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    rfns_cell_ctl_t             ctl;
    logic signed [SAMPLE_W-1:0] left_value;
    logic                       left_greater;

    assign ctl.insert   = insert_en;
    assign ctl.occupied = (CNT_W'(i) < count);
    assign ctl.tail     = (CNT_W'(i) == count);

    if (i == 0) begin : g_head
      assign left_value   = sample;
      assign left_greater = 1'b0;
    end else begin : g_body
      assign left_value   = cell_value[i-1];
      assign left_greater = cell_greater[i-1];
    end

    rfns_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .sample       (sample),
      .left_value   (left_value),
      .left_greater (left_greater),
      .value        (cell_value[i]),
      .greater      (cell_greater[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_go) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_taps    <= taps_next;
      pend_count   <= count_next;
      pend_dropped <= full;
    end
  end

  // The select stage reads the chain while no newer sample has reached it: a
  // new transaction is only taken on the same edge the pending one moves on.
  rfns_select #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_select (
    .clk        (clk),
    .load       (pend_go),
    .cell_value (cell_value),
    .taps       (pend_taps),
    .min_sel    (min_sel),
    .q1_sel     (q1_sel),
    .q3_sel     (q3_sel),
    .lo_sel     (lo_sel),
    .hi_sel     (hi_sel),
    .max_sel    (max_sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
    end else if (pend_go) begin
      sel_valid <= 1'b1;
    end else if (sel_go) begin
      sel_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_go) begin
      sel_count   <= pend_count;
      sel_dropped <= pend_dropped;
    end
  end

  // Twice the median is the exact sum of the two middle entries.
  assign median_next = {lo_sel[SAMPLE_W-1], lo_sel} + {hi_sel[SAMPLE_W-1], hi_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sel_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel_go) begin
      minimum        <= min_sel;
      first_quartile <= q1_sel;
      median_doubled <= median_next;
      third_quartile <= q3_sel;
      maximum        <= max_sel;
      stored_count   <= COUNT_W'(sel_count);
      dropped        <= sel_dropped;
    end
  end

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STORE_DEPTH))
    else $error("fill count exceeds store depth");

  // A transaction against a full store leaves the count untouched.
  assert property (@(posedge clk) disable iff (rst)
    accept && full |=> count == $past(count))
    else $error("full store changed its count");

  // A dropped sample is only reported for a full store.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> stored_count == COUNT_W'(STORE_DEPTH))
    else $error("drop reported on a store that is not full");

  // The summary of a sorted store is ordered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (minimum <= first_quartile) && (first_quartile <= third_quartile)
                  && (third_quartile <= maximum))
    else $error("summary entries out of order");

endmodule

### tb/sv/rfns_summary_checker.sv
// Checker for the running five-number summary unit: watches both channels,
// keeps its own sorted store and compares every result. Depends on rfns_pkg.
`timescale 1ns / 1ps

module rfns_summary_checker #(
  parameter int STORE_DEPTH = rfns_pkg::DEFAULT_STORE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  minimum,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  first_quartile,
  input  logic signed [rfns_pkg::MEDIAN_W-1:0]  median_doubled,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  third_quartile,
  input  logic signed [rfns_pkg::SAMPLE_W-1:0]  maximum,
  input  logic        [rfns_pkg::COUNT_W-1:0]   stored_count,
  input  logic                                  dropped,
  output int                                    pending,
  output int                                    errors
);
  import rfns_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] first_quartile;
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic signed [SAMPLE_W-1:0] third_quartile;
    logic signed [SAMPLE_W-1:0] maximum;
    logic        [COUNT_W-1:0]  stored_count;
    logic                       dropped;
  } summary_t;

  logic signed [SAMPLE_W-1:0] sorted_samples [STORE_DEPTH];
  int                         sample_count;
  summary_t                   expected_summaries [$];

  // Inserts one sample after any equal ones, then reads the summary off the
  // sorted copy. A full store leaves the copy untouched and flags the drop.
  function automatic summary_t insert_and_summarize(logic signed [SAMPLE_W-1:0] value);
    summary_t                   s;
    int                         pos;
    int                         mid;
    logic signed [MEDIAN_W-1:0] lo;
    logic signed [MEDIAN_W-1:0] hi;
    s.dropped = (sample_count >= STORE_DEPTH);
    if (!s.dropped) begin
      pos = sample_count;
      while (pos > 0 && sorted_samples[pos-1] > value) begin
        sorted_samples[pos] = sorted_samples[pos-1];
        pos--;
      end
      sorted_samples[pos] = value;
      sample_count++;
    end
    mid = sample_count / 2;
    if (sample_count % 2 == 0) begin
      lo = sorted_samples[mid-1];
      hi = sorted_samples[mid];
      s.median_doubled = lo + hi;
    end else begin
      s.median_doubled = {sorted_samples[mid], 1'b0};
    end
    s.minimum        = sorted_samples[0];
    s.first_quartile = sorted_samples[sample_count / 4];
    s.third_quartile = sorted_samples[(3 * sample_count) / 4];
    s.maximum        = sorted_samples[sample_count - 1];
    s.stored_count   = sample_count[COUNT_W-1:0];
    return s;
  endfunction

  task automatic compare_field(string name, logic signed [MEDIAN_W-1:0] want,
                               logic signed [MEDIAN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    summary_t want;
    if (rst) begin
      expected_summaries.delete();
      sample_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t ns: result transaction with no sample waiting, expected none, actual count %0d",
                   $time, stored_count);
          errors++;
        end else begin
          want = expected_summaries.pop_front();
          compare_field("minimum", want.minimum, minimum);
          compare_field("first_quartile", want.first_quartile, first_quartile);
          compare_field("median_doubled", want.median_doubled, median_doubled);
          compare_field("third_quartile", want.third_quartile, third_quartile);
          compare_field("maximum", want.maximum, maximum);
          compare_field("stored_count", want.stored_count, stored_count);
          compare_field("dropped", want.dropped, dropped);
        end
      end
      if (in_valid && in_ready)
        expected_summaries.push_back(insert_and_summarize(sample));
    end
    pending = expected_summaries.size();
  end

endmodule

### tb/sv/running_five_number_summary_unit_tb.sv
// Top of the testbench for the running five-number summary unit: clock, reset,
// sample stimulus, result back-pressure and the verdict. Depends on rfns_pkg,
// rfns_summary_checker and the unit itself.
`timescale 1ns / 1ps

module running_five_number_summary_unit_tb;
  import rfns_pkg::*;

  localparam int STORE_DEPTH  = DEFAULT_STORE_DEPTH;
  localparam int RANDOM_ITEMS = 1180;
  // The last stretch of random samples runs with no idling on either side.
  localparam int QUIET_TAIL   = 150;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample    = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] first_quartile;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic signed [SAMPLE_W-1:0] third_quartile;
  logic signed [SAMPLE_W-1:0] maximum;
  logic        [COUNT_W-1:0]  stored_count;
  logic                       dropped;

  int pending;
  int errors;

  // Idle and stall switches; they are set per random sample and change every hundred
  // samples, so that gaps with stalls, gaps only and stalls only take turns.
  logic sender_gaps_on = 1'b0;
  logic stalls_on      = 1'b0;
  int   sent_samples   = 0;

  running_five_number_summary_unit #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .minimum       (minimum),
    .first_quartile(first_quartile),
    .median_doubled(median_doubled),
    .third_quartile(third_quartile),
    .maximum       (maximum),
    .stored_count  (stored_count),
    .dropped       (dropped)
  );

  rfns_summary_checker #(
    .STORE_DEPTH(STORE_DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .minimum       (minimum),
    .first_quartile(first_quartile),
    .median_doubled(median_doubled),
    .third_quartile(third_quartile),
    .maximum       (maximum),
    .stored_count  (stored_count),
    .dropped       (dropped),
    .pending       (pending),
    .errors        (errors)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result back-pressure. A stall is a burst with out_ready low; stall_left
  // counts the cycles of the current burst still to go.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one sample and returns in the time step of the edge at which it
  // was accepted. The optional gap lowers valid for a burst of cycles first;
  // valid is only raised again in a later time step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    int gap;
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_samples++;
  endtask

  // Holds the sender off until every predicted result has been taken. The
  // pending count is looked at on falling edges, where the checker is settled,
  // and the next drive happens on a rising edge again.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Random samples: full-range words exercise every bit, a narrow band around
  // zero and a handful of fixed values give many equal samples, and values
  // next to the signed limits keep the extremes of the store busy.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)
      return $urandom;
    if (pick < 70)
      return int'($urandom_range(0, 64)) - 32;
    if (pick < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'shFFFF_0000;
        1:       return 32'sh0000_0000;
        2:       return 32'sh0001_0000;
        default: return 32'sh0002_0000;
      endcase
    end
    if ($urandom_range(0, 1) == 0)
      return 32'sh7FFF_FFFF - int'($urandom_range(0, 3));
    return 32'sh8000_0000 + int'($urandom_range(0, 3));
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] directed_samples [$];
    int                         idx;

    // The opening samples hit the top of the median range with one and two
    // copies of the largest value, then three copies of the smallest one put
    // both middle entries at the bottom of the range. After that come the
    // small values, the Q16.16 units, alternating bit patterns and a run of
    // equal samples.
    directed_samples = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                         32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000,
                         32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000,
                         32'shFFFF_0000, 32'shAAAA_AAAA, 32'sh5555_5555,
                         32'sh1234_5678, 32'sh1234_5678, 32'sh1234_5678,
                         32'sh1234_5678, 32'sh0000_8000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_samples[k])
      send_sample(directed_samples[k]);

    // Random part. The store fills after STORE_DEPTH samples; everything
    // after that must come back flagged as dropped with the full summary.
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      sender_gaps_on <= (((idx / 100) % 3) != 2) && (idx < RANDOM_ITEMS - QUIET_TAIL);
      stalls_on      <= (((idx / 100) % 3) != 1) && (idx < RANDOM_ITEMS - QUIET_TAIL);
      send_sample(random_sample());
      // Let the pipeline drain once after the eighty-first random sample and once
      // just as the store becomes full.
      if (idx == 80 || sent_samples == STORE_DEPTH)
        wait_for_results();
    end

    wait_for_results();
    // Keep the clock running so that any stray result after the last one shows up.
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog. A correct run takes well under 40 us even with every gap and
  // stall at its longest; this allows many times that.
  initial begin
    #1000000;
    $display("tb: failure");
    $finish;
  end

endmodule

### filelist.f
hdl/rfns_pkg.sv
hdl/rfns_cell.sv
hdl/rfns_select.sv
hdl/running_five_number_summary_unit.sv
tb/sv/rfns_summary_checker.sv
tb/sv/running_five_number_summary_unit_tb.sv
